// ===== hw/rtl/sliding_window_median_defines.svh =====
// Assertion macros shared by the sliding window median RTL
`ifndef SLIDING_WINDOW_MEDIAN_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define SWM_ASSERT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("swm: same-cycle check failed");

// next-cycle implication
`define SWM_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("swm: next-cycle check failed");

`endif

// ===== hw/rtl/swm_pkg.sv =====
// Package: constants and shared types of the sliding window median
`default_nettype none

package swm_pkg;

	localparam int WINDOW_MAX_DEF = 64;
	localparam int DATA_WIDTH_DEF = 32;

	// window_size register
	localparam int WS_W = 7;
	localparam logic [WS_W-1:0] WS_RESET = 7'd3;

	// APB port: one 32-bit register at byte address 0
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic [APB_AW-3:0] REG_WINDOW_SIZE = 1'b0;

	// per-cycle command to the cell row
	typedef struct packed {
		logic shift;  // new sample enters cell 0, the row moves down
		logic clear;  // start of sequence: drop older samples
		logic load;   // probes take the ring neighbor's sample, counts clear
		logic step;   // compare against probe, then rotate probes
	} cell_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/swm_if.sv =====
// Stream interfaces: sample input channel and median output channel
`default_nettype none

interface swm_in_if #(parameter int DATA_WIDTH = swm_pkg::DATA_WIDTH_DEF);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] sample;
	logic                         first_of_sequence;

	modport source (output valid, output sample, output first_of_sequence, input ready);
	modport sink (input valid, input sample, input first_of_sequence, output ready);
endinterface

interface swm_out_if #(parameter int DATA_WIDTH = swm_pkg::DATA_WIDTH_DEF);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] median;

	modport source (output valid, output median, input ready);
	modport sink (input valid, input median, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/swm_cell.sv =====
// One cell of the sample row: sample, probe and rank counter
`default_nettype none

module swm_cell #(
	parameter int DATA_WIDTH = swm_pkg::DATA_WIDTH_DEF,
	parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF,
	parameter int J          = 0
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  swm_pkg::cell_cmd_t              cmd,
	input  logic signed [DATA_WIDTH-1:0]    shift_data,
	input  logic                            valid_in,
	input  logic signed [DATA_WIDTH-1:0]    ring_value,
	input  logic signed [DATA_WIDTH-1:0]    ring_probe,
	input  logic [$clog2(WINDOW_MAX)-1:0]   step_m,
	input  logic [$clog2(WINDOW_MAX)-1:0]   klast,
	input  logic [$clog2(WINDOW_MAX)-1:0]   rank,
	output logic signed [DATA_WIDTH-1:0]    value,
	output logic                            valid,
	output logic signed [DATA_WIDTH-1:0]    probe,
	output logic                            hit
);
	import swm_pkg::*;

	localparam int IDX_W = $clog2(WINDOW_MAX);
	localparam logic [IDX_W-1:0] POS = IDX_W'(J);
	localparam logic FIRST = (J == 0);

	logic signed [DATA_WIDTH-1:0] value_q;
	logic signed [DATA_WIDTH-1:0] probe_q;
	logic                         valid_q;
	logic [IDX_W-1:0]             cnt_q;
	logic                         below;

	// probe sits m places behind in the ring; equal values rank by age
	assign below = (probe_q < value_q) || ((probe_q == value_q) && (step_m <= POS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.shift) begin
			valid_q <= FIRST | (valid_in & ~cmd.clear);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			value_q <= shift_data;
		end
		if (cmd.load) begin
			probe_q <= ring_value;
			cnt_q   <= '0;
		end else if (cmd.step) begin
			probe_q <= ring_probe;
			if (below) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign value = value_q;
	assign valid = valid_q;
	assign probe = probe_q;
	assign hit   = (POS <= klast) && (cnt_q == rank);

endmodule

`default_nettype wire

// ===== hw/rtl/swm_ctrl.sv =====
// Sequencer and window_size register of the sliding window median
`default_nettype none
`include "sliding_window_median_defines.svh"

module swm_ctrl #(
	parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [swm_pkg::APB_AW-1:0]        paddr,
	input  logic [swm_pkg::APB_DW-1:0]        pwdata,
	output logic [swm_pkg::APB_DW-1:0]        prdata,
	output logic                              pready,
	input  logic                              in_valid,
	input  logic                              in_first,
	output logic                              in_ready,
	input  logic [WINDOW_MAX-1:0]             valid_vec,
	input  logic                              out_free,
	output logic                              emit,
	output swm_pkg::cell_cmd_t                cmd,
	output logic [$clog2(WINDOW_MAX)-1:0]     step_m,
	output logic [$clog2(WINDOW_MAX)-1:0]     klast,
	output logic [$clog2(WINDOW_MAX)-1:0]     rank
);
	import swm_pkg::*;

	localparam int IDX_W = $clog2(WINDOW_MAX);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_LOAD = 4'b0010,
		S_RANK = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t            state_q, state_d;
	logic [WS_W-1:0]   ws_q;
	logic [IDX_W-1:0]  m_q, m_d;
	logic [APB_AW-3:0] reg_idx;
	logic              full;
	logic              in_fire;

	assign reg_idx = paddr[APB_AW-1:2];
	assign pready  = 1'b1;
	assign prdata  = (reg_idx == REG_WINDOW_SIZE) ? APB_DW'(ws_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q <= WS_RESET;
		end else if (psel && penable && pwrite && pready && (reg_idx == REG_WINDOW_SIZE)) begin
			ws_q <= pwdata[WS_W-1:0];
		end
	end

	// k - 1, with zero taken as 1 and large values held at WINDOW_MAX
	always_comb begin
		if (ws_q == '0) begin
			klast = '0;
		end else if (32'(ws_q) > 32'(WINDOW_MAX)) begin
			klast = IDX_W'(WINDOW_MAX - 1);
		end else begin
			klast = IDX_W'(ws_q - 1'b1);
		end
	end

	assign rank     = klast >> 1;
	assign full     = valid_vec[klast];
	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign step_m   = m_q;

	always_comb begin
		state_d   = state_q;
		m_d       = m_q;
		cmd       = '0;
		emit      = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					cmd.shift = 1'b1;
					cmd.clear = in_first;
					state_d   = S_LOAD;
				end
			end
			S_LOAD: begin
				if (!full) begin
					state_d = S_IDLE;
				end else begin
					cmd.load = 1'b1;
					m_d      = IDX_W'(1);
					state_d  = (klast == '0) ? S_DONE : S_RANK;
				end
			end
			S_RANK: begin
				cmd.step = 1'b1;
				m_d      = m_q + 1'b1;
				if (m_q == klast) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			m_q     <= '0;
		end else begin
			state_q <= state_d;
			m_q     <= m_d;
		end
	end

	`SWM_ASSERT_NEXT(a_fire_to_load, in_fire, state_q == S_LOAD)
	`SWM_ASSERT(a_step_in_range, state_q == S_RANK, (m_q != '0) && (m_q <= klast))
	`SWM_ASSERT(a_done_needs_full, state_q == S_DONE, valid_vec[klast])

endmodule

`default_nettype wire

// ===== hw/rtl/sliding_window_median.sv =====
// Top level: sliding window median over a row of sample cells
//
// Samples arrive on "samples" (valid/ready); medians leave on "medians"
// (valid/ready). window_size (k) is written over the APB port at address 0;
// the user writes it only while the block is idle, which the block does not
// enforce. The row keeps the WINDOW_MAX newest samples, newest in cell 0.
// After each sample, once at least k samples have arrived since the last
// first_of_sequence, one median goes out: the lower median of the k newest
// samples. Before that, a sample gives no result. After a sample is taken,
// S_LOAD loads the probes, S_RANK rotates them through the first k cells
// while each of those cells counts how many samples rank below its own,
// and S_DONE writes the result register; with no result, S_LOAD goes idle.
// One item is in work at a time; samples.ready is high only when idle.
// The result register decouples the output: a stalled receiver holds the
// median and the block waits with the next result until it is taken.
// Reset empties the row, drops any result and sets window_size to 3.
`default_nettype none
`include "sliding_window_median_defines.svh"

module sliding_window_median #(
	parameter int DATA_WIDTH = swm_pkg::DATA_WIDTH_DEF,
	parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	swm_in_if.sink                     samples,
	swm_out_if.source                  medians,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [swm_pkg::APB_AW-1:0] paddr,
	input  logic [swm_pkg::APB_DW-1:0] pwdata,
	output logic [swm_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);
	import swm_pkg::*;

	localparam int IDX_W = $clog2(WINDOW_MAX);

	cell_cmd_t                    cmd;
	logic [IDX_W-1:0]             step_m;
	logic [IDX_W-1:0]             klast;
	logic [IDX_W-1:0]             rank;
	logic                         emit;
	logic                         out_free;
	logic                         in_ready;
	logic signed [DATA_WIDTH-1:0] value_w [WINDOW_MAX];
	logic signed [DATA_WIDTH-1:0] probe_w [WINDOW_MAX];
	logic [WINDOW_MAX-1:0]        valid_w;
	logic [WINDOW_MAX-1:0]        hit_w;
	logic signed [DATA_WIDTH-1:0] median_sel;
	logic signed [DATA_WIDTH-1:0] median_q;
	logic                         out_valid_q;

	assign out_free      = !out_valid_q || medians.ready;
	assign samples.ready = in_ready;

	swm_ctrl #(
		.WINDOW_MAX (WINDOW_MAX)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (samples.valid),
		.in_first  (samples.first_of_sequence),
		.in_ready  (in_ready),
		.valid_vec (valid_w),
		.out_free  (out_free),
		.emit      (emit),
		.cmd       (cmd),
		.step_m    (step_m),
		.klast     (klast),
		.rank      (rank)
	);

	// cell 0 closes the ring at cell k-1
	for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_cell
		if (j == 0) begin : g_head
			swm_cell #(
				.DATA_WIDTH (DATA_WIDTH),
				.WINDOW_MAX (WINDOW_MAX),
				.J          (j)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.cmd        (cmd),
				.shift_data (samples.sample),
				.valid_in   (1'b1),
				.ring_value (value_w[klast]),
				.ring_probe (probe_w[klast]),
				.step_m     (step_m),
				.klast      (klast),
				.rank       (rank),
				.value      (value_w[j]),
				.valid      (valid_w[j]),
				.probe      (probe_w[j]),
				.hit        (hit_w[j])
			);
		end else begin : g_body
			swm_cell #(
				.DATA_WIDTH (DATA_WIDTH),
				.WINDOW_MAX (WINDOW_MAX),
				.J          (j)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.cmd        (cmd),
				.shift_data (value_w[j-1]),
				.valid_in   (valid_w[j-1]),
				.ring_value (value_w[j-1]),
				.ring_probe (probe_w[j-1]),
				.step_m     (step_m),
				.klast      (klast),
				.rank       (rank),
				.value      (value_w[j]),
				.valid      (valid_w[j]),
				.probe      (probe_w[j]),
				.hit        (hit_w[j])
			);
		end
	end

	// exactly one cell in the window holds the wanted rank
	always_comb begin
		median_sel = '0;
		for (int j = 0; j < WINDOW_MAX; j++) begin
			if (hit_w[j]) begin
				median_sel = median_sel | value_w[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (medians.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			median_q <= median_sel;
		end
	end

	assign medians.valid  = out_valid_q;
	assign medians.median = median_q;

	`SWM_ASSERT(a_single_rank_hit, emit, $onehot(hit_w))
	`SWM_ASSERT_NEXT(a_emit_shows, emit, medians.valid)
	`SWM_ASSERT_NEXT(a_one_in_work, samples.valid && samples.ready, !samples.ready)

endmodule

`default_nettype wire
